// File: hdl/sgr_pkg.sv
// Shared types and constants for the stream group reverser.
// Used by the front, queue, back and top modules; depends on nothing.
`default_nettype none

package sgr_pkg;

	// Buffer geometry
	localparam int MAX_GROUP   = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int IDX_W       = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int SIZE_W      = $clog2(MAX_GROUP + 1);
	localparam int NUM_BANKS   = 2;
	localparam int BANK_W      = 1;
	localparam int ADDR_W      = BANK_W + IDX_W;
	localparam int MEM_DEPTH   = NUM_BANKS * MAX_GROUP;

	// Group size register
	localparam int CFG_W       = 5;
	localparam int CMP_W       = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

	// Descriptor queue between front and back
	localparam int QUEUE_DEPTH = NUM_BANKS;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input transfer payload
	typedef struct packed {
		logic signed [31:0] value;
		logic               list_end;
	} in_item_t;

	// Output transfer payload
	typedef struct packed {
		logic signed [31:0] out_value;
		logic               burst_last;
		logic               list_done;
	} out_item_t;

	// One closed group waiting to be drained
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [IDX_W-1:0]  last_idx;
		logic              reverse;
		logic              list_end;
	} desc_t;

	// Buffer write from the front
	typedef struct packed {
		logic                  en;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] data;
	} buf_wr_t;

	// Bank hand-back from the back
	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} bank_rel_t;

endpackage

`default_nettype wire

// File: hdl/sgr_front.sv
// Front end: accepts input transfers, fills the ping-pong banks and closes groups.
// Depends on sgr_pkg; feeds sgr_queue and the buffer write port in sgr_back.
`default_nettype none

module sgr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sgr_pkg::in_item_t  in_data,
	output sgr_pkg::buf_wr_t        buf_wr,
	output logic                    q_push,
	output sgr_pkg::desc_t          q_desc,
	input  wire logic               q_ready,
	input  wire sgr_pkg::bank_rel_t bank_rel
);
	import sgr_pkg::*;

	logic [CFG_W-1:0]     group_size_q;
	logic [IDX_W-1:0]     fill_q;
	logic [BANK_W-1:0]    wbank_q;
	logic [NUM_BANKS-1:0] busy_q;
	logic [NUM_BANKS-1:0] busy_next;
	logic [CMP_W-1:0]     size_cmp;
	logic [SIZE_W-1:0]    size_eff;
	logic [SIZE_W-1:0]    total;
	logic                 accept;
	logic                 full_group;
	logic                 close;

	// Clamp the group size to 1..MAX_GROUP
	assign size_cmp = CMP_W'(group_size_q);
	always_comb begin
		if (size_cmp == '0) begin
			size_eff = SIZE_W'(1);
		end else if (size_cmp > CMP_W'(MAX_GROUP)) begin
			size_eff = SIZE_W'(MAX_GROUP);
		end else begin
			size_eff = SIZE_W'(size_cmp);
		end
	end

	// Classify the incoming element
	assign total      = SIZE_W'(fill_q) + SIZE_W'(1);
	assign full_group = (total >= size_eff);
	assign close      = full_group || in_data.list_end;
	assign in_ready   = !busy_q[wbank_q] && q_ready;
	assign accept     = in_valid && in_ready;

	// Buffer write and group descriptor
	assign buf_wr.en        = accept;
	assign buf_wr.addr      = {wbank_q, fill_q};
	assign buf_wr.data      = DATA_WIDTH'(in_data.value);
	assign q_push           = accept && close;
	assign q_desc.bank      = wbank_q;
	assign q_desc.last_idx  = fill_q;
	assign q_desc.reverse   = full_group;
	assign q_desc.list_end  = in_data.list_end;

	// Bank ownership: set on close, cleared when the back has read the bank out
	always_comb begin
		busy_next = busy_q;
		if (bank_rel.valid) begin
			busy_next[bank_rel.bank] = 1'b0;
		end
		if (q_push) begin
			busy_next[wbank_q] = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= CFG_RESET;
			fill_q       <= '0;
			wbank_q      <= '0;
			busy_q       <= '0;
		end else begin
			if (cfg_we) begin
				group_size_q <= cfg_wdata;
			end
			busy_q <= busy_next;
			if (accept) begin
				if (close) begin
					fill_q  <= '0;
					wbank_q <= wbank_q + BANK_W'(1);
				end else begin
					fill_q <= fill_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/sgr_queue.sv
// Short descriptor FIFO between the front and the back.
// Depends on sgr_pkg.
`default_nettype none

module sgr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sgr_pkg::desc_t push_desc,
	output logic                ready,
	output logic                head_valid,
	output sgr_pkg::desc_t      head_desc,
	input  wire logic           pop
);
	import sgr_pkg::*;

	desc_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign ready      = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/sgr_back.sv
// Back end: holds the two-bank group buffer and drains closed groups in order.
// Depends on sgr_pkg; takes descriptors from sgr_queue, writes from sgr_front.
`default_nettype none

module sgr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sgr_pkg::buf_wr_t buf_wr,
	input  wire logic             q_valid,
	input  wire sgr_pkg::desc_t   q_desc,
	output logic                  q_pop,
	output sgr_pkg::bank_rel_t    bank_rel,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sgr_pkg::out_item_t    out_data
);
	import sgr_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [MEM_DEPTH];
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      offset;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  last;
	logic                  issue;
	logic [DATA_WIDTH-1:0] rdata_s1;
	logic                  burst_last_s1;
	logic                  list_done_s1;
	logic                  valid_s1;

	// Read sequencing over the head group
	assign offset  = q_desc.reverse ? (q_desc.last_idx - pos_q) : pos_q;
	assign rd_addr = {q_desc.bank, offset};
	assign last    = (pos_q == q_desc.last_idx);
	assign issue   = q_valid && (!valid_s1 || out_ready);
	assign q_pop   = issue && last;

	// Bank goes back to the front once its last entry is read
	assign bank_rel.valid = q_pop;
	assign bank_rel.bank  = q_desc.bank;

	// Buffer memory with registered read, the read register is the output stage
	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem_q[buf_wr.addr] <= buf_wr.data;
		end
		if (issue) begin
			rdata_s1      <= mem_q[rd_addr];
			burst_last_s1 <= last;
			list_done_s1  <= last && q_desc.list_end;
		end
	end

	// Position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (issue) begin
				pos_q <= last ? '0 : pos_q + IDX_W'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign out_valid            = valid_s1;
	assign out_data.out_value   = 32'(rdata_s1);
	assign out_data.burst_last  = burst_last_s1;
	assign out_data.list_done   = list_done_s1;

endmodule

`default_nettype wire

// File: hdl/stream_group_reverser_top.sv
// Stream group reverser: takes a list one element per transfer and returns it
// reversed in groups of group_size (1..16; 0 acts as 1, larger values as 16).
// A group that is cut short by list_end comes out in arrival order, and a group
// size of one passes elements straight through. Every result burst flags its
// last result with burst_last, and the last result of the list has list_done.
// With full groups of one size the rate is one element in and one result out
// per cycle: the front fills one of two 16-entry banks while the back drains
// the other through a single read port. The input stalls while both banks hold
// closed groups. That happens when the output side stalls, and also when a
// short group (list end or a lowered size) closes while a longer one is still
// draining; the input then waits until that drain finishes. The first result of
// a group passes through the descriptor queue and then the read register in sgr_back.
// Depends on sgr_pkg, sgr_front, sgr_queue and sgr_back.
`default_nettype none

module stream_group_reverser_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sgr_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sgr_pkg::out_item_t      out_data
);
	import sgr_pkg::*;

	buf_wr_t   buf_wr;
	bank_rel_t bank_rel;
	desc_t     push_desc;
	desc_t     head_desc;
	logic      q_push;
	logic      q_ready;
	logic      q_valid;
	logic      q_pop;

	// Accept and classify
	sgr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.buf_wr   (buf_wr),
		.q_push   (q_push),
		.q_desc   (push_desc),
		.q_ready  (q_ready),
		.bank_rel (bank_rel)
	);

	// Closed groups in order
	sgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.ready     (q_ready),
		.head_valid(q_valid),
		.head_desc (head_desc),
		.pop       (q_pop)
	);

	// Drain groups to the output
	sgr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.buf_wr   (buf_wr),
		.q_valid  (q_valid),
		.q_desc   (head_desc),
		.q_pop    (q_pop),
		.bank_rel (bank_rel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// Front never writes the bank the back is handing back
	a_no_write_released_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_wr.en && bank_rel.valid) |-> (buf_wr.addr[ADDR_W-1 -: BANK_W] != bank_rel.bank))
		else $error("buffer write into a bank still being drained");

	// Queue never overflows
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("descriptor pushed into a full queue");

	// A bank is released only while a group is at the queue head
	a_release_has_group: assert property (@(posedge clk) disable iff (!arst_n)
		bank_rel.valid |-> q_valid)
		else $error("bank released with no group pending");

	// End of list always closes a burst
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.list_done) |-> out_data.burst_last)
		else $error("list_done without burst_last");
`endif

endmodule

`default_nettype wire

// File: verif/stream_group_reverser_top_tb.sv
// Testbench for stream_group_reverser_top: a directed table, then random lists
// over several group sizes and handshake pressure, checked against a predictor or typed rows.
// Depends on sgr_pkg and the stream_group_reverser_top RTL.

module stream_group_reverser_top_tb;
	import sgr_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_SHOWN     = 10;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 30;
	localparam int NUM_ROWS      = 23;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One directed step: a group size write or an input transfer
	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] val;
		logic        list_end;
		logic        typed;
		out_item_t   want_res;
	} stim_row_t;

	// Rows with typed set carry their single result; the rest go to the predictor
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		'{ROW_ITEM, 32'h7FFFFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h80000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000005, 1'b1, 1'b1, '{32'sh00000005, 1'b1, 1'b1}},
		'{ROW_ITEM, 32'hFFFFFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000000, 1'b1, 1'b0, '0},
		'{ROW_CFG,  32'd1,        1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h80000000, 1'b0, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h7FFFFFFF, 1'b1, 1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b1}},
		'{ROW_CFG,  32'd0,        1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'hFFFFFFFF, 1'b0, 1'b1, '{32'shFFFFFFFF, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h00000000, 1'b1, 1'b1, '{32'sh00000000, 1'b1, 1'b1}},
		'{ROW_CFG,  32'd4,        1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000001, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000002, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000003, 1'b0, 1'b0, '0},
		// size drops to 2 with three buffered: next element flushes all four
		'{ROW_CFG,  32'd2,        1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000004, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h12345678, 1'b1, 1'b1, '{32'sh12345678, 1'b1, 1'b1}},
		'{ROW_CFG,  32'd3,        1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000010, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'h00000020, 1'b1, 1'b0, '0},
		// above the buffer depth: size saturates to 16, a lone element is a short tail
		'{ROW_CFG,  32'd17,       1'b0, 1'b0, '0},
		'{ROW_ITEM, 32'hA5A5A5A5, 1'b1, 1'b1, '{32'shA5A5A5A5, 1'b1, 1'b1}}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;

	// Predictor state
	logic [31:0] grp_buf [MAX_GROUP];
	int          grp_fill;
	logic [4:0]  grp_size_reg;
	out_item_t   pending_results[$];

	int idle_pct  = 0;
	int stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;

	stream_group_reverser_top i_dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_wdata,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data
	);

	always #HALF_PERIOD clk = ~clk;

	// Buffer one element and return whatever burst it releases
	function automatic void reorder_predict(input in_item_t it, ref out_item_t res[$]);
		int eff;
		int total;
		out_item_t r;
		if (grp_size_reg == 0) begin
			eff = 1;
		end else if (grp_size_reg > MAX_GROUP) begin
			eff = MAX_GROUP;
		end else begin
			eff = int'(grp_size_reg);
		end
		if (grp_fill >= MAX_GROUP) begin
			grp_fill = MAX_GROUP - 1;
		end
		grp_buf[grp_fill] = it.value;
		total = grp_fill + 1;
		if (total >= eff) begin
			// full group: newest first
			for (int i = total; i > 0; i--) begin
				r.out_value  = grp_buf[i-1];
				r.burst_last = (i == 1);
				r.list_done  = (i == 1) && it.list_end;
				res.push_back(r);
			end
			grp_fill = 0;
		end else if (it.list_end) begin
			// short tail of the list: arrival order
			for (int i = 0; i < total; i++) begin
				r.out_value  = grp_buf[i];
				r.burst_last = (i == total - 1);
				r.list_done  = (i == total - 1);
				res.push_back(r);
			end
			grp_fill = 0;
		end else begin
			grp_fill = total;
		end
	endfunction

	// Wait until every expected result is out and the block has settled
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [4:0] sz);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we       <= 1'b0;
		grp_size_reg = sz;
	endtask

	// One input transfer, with an optional idle gap ahead of it
	task automatic send_item(input in_item_t it, input logic typed, input out_item_t want_res);
		out_item_t burst[$];
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		reorder_predict(it, burst);
		if (typed) begin
			pending_results.push_back(want_res);
		end else begin
			foreach (burst[k]) pending_results.push_back(burst[k]);
		end
	endtask

	// Receiver backpressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				if (err_count < MAX_SHOWN) begin
					$display("unexpected result: value %h burst_last %b list_done %b",
						out_data.out_value, out_data.burst_last, out_data.list_done);
				end
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.out_value !== want.out_value ||
						out_data.burst_last !== want.burst_last ||
						out_data.list_done !== want.list_done) begin
					if (err_count < MAX_SHOWN) begin
						$display("result differs: expected %h/%b/%b, got %h/%b/%b",
							want.out_value, want.burst_last, want.list_done,
							out_data.out_value, out_data.burst_last, out_data.list_done);
					end
					err_count++;
				end
			end
		end
	end

	// Hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("stream_group_reverser_top: mismatch");
			$finish;
		end
	end

	// Stimulus
	initial begin
		in_item_t   it;
		int         remaining;
		int         eff;
		logic [4:0] phase_size;
		grp_fill     = 0;
		grp_size_reg = CFG_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset group size first
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				write_group_size(DIRECTED[r].val[4:0]);
			end else begin
				it.value    = DIRECTED[r].val;
				it.list_end = DIRECTED[r].list_end;
				send_item(it, DIRECTED[r].typed, DIRECTED[r].want_res);
			end
		end

		// random lists; a list may straddle a size change
		remaining = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			case (p)
				0: phase_size = 5'd1;
				1: phase_size = 5'd16;
				2: phase_size = 5'd31;
				3: phase_size = 5'd0;
				4: phase_size = 5'd17;
				5: phase_size = 5'($urandom_range(2, 15));
				6: phase_size = 5'd3;
				default: phase_size = 5'($urandom_range(0, 31));
			endcase
			write_group_size(phase_size);
			if (phase_size == 0) begin
				eff = 1;
			end else if (phase_size > MAX_GROUP) begin
				eff = MAX_GROUP;
			end else begin
				eff = int'(phase_size);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (remaining == 0) begin
					remaining = $urandom_range(1, 2 * eff + 3);
				end
				remaining--;
				case ($urandom_range(7))
					0: it.value = 32'sh7FFFFFFF;
					1: it.value = 32'sh80000000;
					2: it.value = '1;
					3: it.value = '0;
					default: it.value = $urandom();
				endcase
				it.list_end = (remaining == 0) || (p == NUM_PHASES - 1 && n == PHASE_ITEMS - 1);
				if (it.list_end) begin
					remaining = 0;
				end
				send_item(it, 1'b0, '0);
			end
		end

		// drain
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("stream_group_reverser_top: match");
		end else begin
			$display("stream_group_reverser_top: mismatch");
		end
		$finish;
	end

endmodule

// File: stream_group_reverser_top.f
hdl/sgr_pkg.sv
hdl/sgr_front.sv
hdl/sgr_queue.sv
hdl/sgr_back.sv
hdl/stream_group_reverser_top.sv
verif/stream_group_reverser_top_tb.sv
